/* hw/rtl/i2ce_pkg.sv */
// Shared command codes, status codes, constants and memory control type for the EEPROM slave.
`timescale 1ns / 1ps
`default_nettype none
package i2ce_pkg;

    // Bus event and byte commands
    localparam logic [2:0] CMD_START_WRITE = 3'd0;
    localparam logic [2:0] CMD_START_READ  = 3'd1;
    localparam logic [2:0] CMD_FINISH      = 3'd2;
    localparam logic [2:0] CMD_NACK        = 3'd3;
    localparam logic [2:0] CMD_SEND_BYTE   = 3'd4;
    localparam logic [2:0] CMD_RECV_BYTE   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_WR_REFUSED = 2'd1;
    localparam logic [1:0] ST_RD_REFUSED = 2'd2;

    // Erased memory contents and size register constants
    localparam logic [7:0] ERASED_BYTE     = 8'hFF;
    localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;
    localparam logic [3:0] SIZE_LOG2_MIN   = 4'd8;
    localparam logic [4:0] TWO_BYTE_LOG2   = 5'd11;

    // Memory access strobes from the controller to the storage array
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage
`default_nettype wire

/* hw/rtl/i2ce_ram.sv */
// Byte storage array with registered read data and an erase sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
module i2ce_ram #(
    parameter int MEM_BYTES = 8192
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  i2ce_pkg::t_mem_ctl             i_ctl,
    input  wire [$clog2(MEM_BYTES)-1:0]    i_addr,
    input  wire [7:0]                      i_wdata,
    output logic [7:0]                     o_rdata,
    output logic                           o_busy
);
    import i2ce_pkg::*;

    localparam int ADDR_W = $clog2(MEM_BYTES);

    logic [7:0]        r_mem [MEM_BYTES];
    logic [7:0]        r_rdata;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    // During the erase sweep the sweep counter owns the write port.
    assign wr_en   = r_clearing | i_ctl.wr_en;
    assign wr_addr = r_clearing ? r_clr_addr : i_addr;
    assign wr_data = r_clearing ? ERASED_BYTE : i_wdata;

    // Erase sweep control: one entry per cycle from address zero upward.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(MEM_BYTES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Storage array: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule
`default_nettype wire

/* hw/rtl/i2c_eeprom_slave_unit.sv */
// Top level of the byte-level serial EEPROM slave: command decode, address state, result stage.
//
// Usage: bus events and bytes enter on the input channel (i_in_valid, o_in_ready, i_cmd,
// i_data). Every accepted beat yields exactly one result beat on the output channel
// (o_out_valid, i_out_ready, o_rdata, o_status), in order. The size register is written
// through the configuration channel (i_cfg_valid, o_cfg_ready, i_size_log2), which is
// always ready and should only be written while no result is pending.
// Results: each result is registered on the edge that accepts its beat; the memory read for a
// receive byte is issued on the accept edge and its data lands in the result stage.
// Throughput: one beat per cycle while no erase sweep runs and the receiver takes each result;
// each beat issues at most one memory read or one memory write.
// Reset: the erase sweep writes 0xFF into all MEM_BYTES entries, one per cycle, and the
// input channel stays not ready until the sweep ends. The size register returns to 10 and
// the address state clears at once.
// Stalls: while the result stage holds a beat that the receiver does not take, the input
// channel is held off; the result beat stays stable until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module i2c_eeprom_slave_unit #(
    parameter int MEM_BYTES = 8192
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire [2:0]  i_cmd,
    input  wire [7:0]  i_data,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [7:0] o_rdata,
    output logic [1:0] o_status,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [3:0]  i_size_log2
);
    import i2ce_pkg::*;

    localparam int ADDR_W = $clog2(MEM_BYTES);

    typedef enum logic [1:0] {
        MODE_STOPPED    = 2'd0,
        MODE_ADDRESSING = 2'd1,
        MODE_READING    = 2'd2,
        MODE_WRITING    = 2'd3
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [15:0] r_addr, n_addr;
    logic [1:0]  r_seen, n_seen;
    logic [3:0]  r_size_log2;
    logic        r_out_valid;
    logic [1:0]  r_status, n_status;
    logic        r_out_is_read, n_is_read;

    logic              in_fire;
    logic              mem_busy;
    logic [7:0]        mem_rdata;
    t_mem_ctl          mem_ctl;
    logic [4:0]        eff_log2;
    logic [4:0]        clamp_log2;
    logic [15:0]       size_mask;
    logic              two_byte;
    logic [15:0]       idx16;
    logic [15:0]       next_idx16;
    logic [1:0]        seen_inc;
    logic              addr_done;
    logic [15:0]       assembled;

    // Handshakes: the result stage acts as the output register.
    assign o_in_ready  = !mem_busy && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Effective size: clamp the register below, then to the memory depth.
    assign clamp_log2 = (r_size_log2 < SIZE_LOG2_MIN) ? {1'b0, SIZE_LOG2_MIN}
                                                      : {1'b0, r_size_log2};
    assign eff_log2   = (clamp_log2 > 5'(ADDR_W)) ? 5'(ADDR_W) : clamp_log2;
    assign size_mask  = 16'((17'd1 << eff_log2) - 17'd1);
    assign two_byte   = eff_log2 >= TWO_BYTE_LOG2;

    // Current location and its wrapped successor.
    assign idx16      = r_addr & size_mask;
    assign next_idx16 = (idx16 + 16'd1) & size_mask;

    // Address collection: the high byte first when two bytes are used.
    assign seen_inc  = r_seen + 2'd1;
    assign addr_done = seen_inc >= (two_byte ? 2'd2 : 2'd1);
    assign assembled = (two_byte && r_seen == 2'd0) ? {i_data, 8'h00}
                     : {((r_seen == 2'd0) ? 8'h00 : r_addr[15:8]), i_data};

    // Command decode and next state.
    always_comb begin
        n_mode    = r_mode;
        n_addr    = r_addr;
        n_seen    = r_seen;
        n_status  = ST_OK;
        n_is_read = 1'b0;
        mem_ctl   = '0;
        if (in_fire) begin
            case (i_cmd)
                CMD_START_WRITE: begin
                    n_mode = MODE_ADDRESSING;
                    n_seen = 2'd0;
                end
                CMD_START_READ: begin
                    n_mode = MODE_READING;
                    n_seen = 2'd0;
                end
                CMD_FINISH: begin
                    n_mode = MODE_STOPPED;
                    n_seen = 2'd0;
                end
                CMD_SEND_BYTE: begin
                    if (r_mode == MODE_ADDRESSING) begin
                        if (addr_done) begin
                            n_addr = assembled & size_mask;
                            n_mode = MODE_WRITING;
                            n_seen = 2'd0;
                        end else begin
                            n_addr = assembled;
                            n_seen = seen_inc;
                        end
                    end else if (r_mode == MODE_WRITING) begin
                        mem_ctl.wr_en = 1'b1;
                        n_addr        = next_idx16;
                    end else begin
                        n_status = ST_WR_REFUSED;
                    end
                end
                CMD_RECV_BYTE: begin
                    if (r_mode == MODE_READING) begin
                        mem_ctl.rd_en = 1'b1;
                        n_is_read     = 1'b1;
                        n_addr        = next_idx16;
                    end else begin
                        n_status = ST_RD_REFUSED;
                    end
                end
                default: begin
                    // A NACK and the unused codes leave the state alone.
                end
            endcase
        end
    end

    // State, configuration register and result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_STOPPED;
            r_addr        <= '0;
            r_seen        <= '0;
            r_size_log2   <= SIZE_LOG2_RESET;
            r_out_valid   <= 1'b0;
            r_out_is_read <= 1'b0;
            r_status      <= ST_OK;
        end else begin
            r_mode <= n_mode;
            r_addr <= n_addr;
            r_seen <= n_seen;
            if (i_cfg_valid && o_cfg_ready) begin
                r_size_log2 <= i_size_log2;
            end
            if (in_fire) begin
                r_out_valid   <= 1'b1;
                r_status      <= n_status;
                r_out_is_read <= n_is_read;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    i2ce_ram #(
        .MEM_BYTES(MEM_BYTES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (mem_ctl),
        .i_addr (idx16[ADDR_W-1:0]),
        .i_wdata(i_data),
        .o_rdata(mem_rdata),
        .o_busy (mem_busy)
    );

    // Read data only reaches the port for a successful receive byte.
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_rdata     = r_out_is_read ? mem_rdata : 8'h00;

    // No beat is taken while the erase sweep runs.
    a_no_accept_while_erasing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_busy |-> !o_in_ready)
        else $error("input accepted during erase sweep");

    // A refused beat never carries read data.
    a_refused_has_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_rdata == 8'h00))
        else $error("refused result carries data");

    // The byte counter is only live while collecting an address.
    a_seen_idle_outside_addressing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_ADDRESSING) |-> (r_seen == 2'd0))
        else $error("address byte count left set outside addressing");

    // A memory access always produces a result beat in the next cycle.
    a_access_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_ctl.wr_en || mem_ctl.rd_en) |=> o_out_valid)
        else $error("memory access without result beat");

    // Reads and writes never share a beat.
    a_single_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("read and write issued together");

endmodule
`default_nettype wire
